FILE: rtl/core/i2a_pkg.sv
// Shared types, constants and helper functions for the integer to ASCII formatter.
// Used by the front, queue, back and top-level modules; depends on nothing else.

package i2a_pkg;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // ASCII bases for digits and letters.
  localparam logic [6:0] DIGIT_ZERO = 7'd48;
  localparam logic [6:0] LOWER_A    = 7'd97;
  localparam logic [6:0] UPPER_A    = 7'd65;
  localparam logic [6:0] HEX_TEN    = 7'd10;

  // Formatting modes.
  typedef enum logic [1:0] {
    CMD_DEC    = 2'd0,
    CMD_HEX_LO = 2'd1,
    CMD_HEX_UP = 2'd2,
    CMD_HEX64  = 2'd3
  } cmd_e;

  // One classified item as it sits in the queue.
  // top is the position of the most significant digit to print.
  typedef struct packed {
    cmd_e        cmd;
    logic [63:0] value;
    logic [3:0]  top;
  } entry_t;

  // Powers of ten for the decimal digit positions; unused positions never match.
  function automatic logic [33:0] dec_pow(input logic [3:0] pos);
    logic [33:0] res;
    case (pos)
      4'd0:    res = 34'd1;
      4'd1:    res = 34'd10;
      4'd2:    res = 34'd100;
      4'd3:    res = 34'd1000;
      4'd4:    res = 34'd10000;
      4'd5:    res = 34'd100000;
      4'd6:    res = 34'd1000000;
      4'd7:    res = 34'd10000000;
      4'd8:    res = 34'd100000000;
      4'd9:    res = 34'd1000000000;
      default: res = '1;
    endcase
    return res;
  endfunction

  // ASCII code of one digit value, with the letter case chosen by upper.
  function automatic logic [6:0] hex_char(input logic [3:0] d, input logic upper);
    logic [6:0] res;
    if (d <= 4'd9) begin
      res = DIGIT_ZERO + {3'b000, d};
    end else begin
      res = (upper ? UPPER_A : LOWER_A) + {3'b000, d} - HEX_TEN;
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/i2a_front.sv
// Front end of the formatter: takes input items and classifies them.
// Finds the leading digit position for each mode; depends on i2a_pkg.

module i2a_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [63:0]         value_i,
  input  logic                q_full_i,
  output logic                push_o,
  output i2a_pkg::entry_t     entry_o
);

  i2a_pkg::cmd_e cmd;
  logic [63:0]   value_m;
  logic [3:0]    top_hex;
  logic [3:0]    top_dec;

  assign cmd = i2a_pkg::cmd_e'(cmd_i);

  // The 32-bit modes see only the low word.
  assign value_m = (cmd == i2a_pkg::CMD_HEX64) ? value_i : {32'd0, value_i[31:0]};

  // Highest nonzero nibble; zero gives position zero.
  always_comb begin
    top_hex = '0;
    for (int i = 0; i < 16; i++) begin
      if (value_m[i*4 +: 4] != 4'd0) begin
        top_hex = 4'(i);
      end
    end
  end

  // Number of powers of ten not above the value gives the top decimal position.
  always_comb begin
    top_dec = '0;
    for (int i = 1; i < 10; i++) begin
      if ({2'b00, value_m[31:0]} >= i2a_pkg::dec_pow(4'(i))) begin
        top_dec = top_dec + 4'd1;
      end
    end
  end

  // Handshake toward the queue.
  assign in_stall_o    = q_full_i;
  assign push_o        = in_valid_i && !q_full_i;
  assign entry_o.cmd   = cmd;
  assign entry_o.value = value_m;
  assign entry_o.top   = (cmd == i2a_pkg::CMD_DEC) ? top_dec : top_hex;

endmodule

FILE: rtl/core/i2a_queue.sv
// Short queue of classified items between the front and the back.
// Register storage with one read port; depends on i2a_pkg.

module i2a_queue #(
  parameter int unsigned Depth = i2a_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  i2a_pkg::entry_t entry_i,
  input  logic            pop_i,
  output i2a_pkg::entry_t entry_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2a_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign entry_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: rtl/core/i2a_back.sv
// Back end of the formatter: emits one ASCII digit per cycle while the output is not stalled, top digit first.
// Decimal digits come from a compare against the multiples of a power of ten; depends on i2a_pkg.

module i2a_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  i2a_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [6:0]      ascii_char_o,
  output logic            last_char_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e        state_q;
  i2a_pkg::cmd_e cmd_q;
  logic [63:0]   value_q;
  logic [3:0]    pos_q;
  logic          out_valid_q;
  logic [6:0]    char_q;
  logic          last_q;

  logic [33:0]   mult_tab [16][10];
  logic [8:0]    ge;
  logic [3:0]    dec_digit;
  logic [31:0]   rem_next;
  logic [3:0]    digit;
  logic          advance;
  logic          emit;
  logic          done;

  // Multiples k * 10^p of each decimal position; rows past the top never match.
  for (genvar p = 0; p < 16; p++) begin : g_row
    for (genvar k = 0; k < 10; k++) begin : g_col
      if (p <= 9) begin : g_used
        assign mult_tab[p][k] = 34'(k) * i2a_pkg::dec_pow(4'(p));
      end else begin : g_unused
        assign mult_tab[p][k] = (k == 0) ? 34'd0 : '1;
      end
    end
  end

  // Decimal digit: count how many multiples the remainder reaches.
  always_comb begin
    for (int k = 1; k < 10; k++) begin
      ge[k-1] = ({2'b00, value_q[31:0]} >= mult_tab[pos_q][k]);
    end
  end

  assign dec_digit = 4'($countones(ge));
  assign rem_next  = 32'({2'b00, value_q[31:0]} - mult_tab[pos_q][dec_digit]);
  assign digit     = (cmd_q == i2a_pkg::CMD_DEC) ? dec_digit : value_q[pos_q*4 +: 4];

  // Handshake: a digit goes out when the output register is free or being taken.
  assign advance = !out_valid_q || !out_stall_i;
  assign emit    = (state_q == ST_EMIT) && advance;
  assign done    = emit && (pos_q == 4'd0);
  assign q_pop_o = !q_empty_i && ((state_q == ST_IDLE) || done);

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= i2a_pkg::CMD_DEC;
      value_q     <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        char_q      <= i2a_pkg::hex_char(digit, cmd_q == i2a_pkg::CMD_HEX_UP);
        last_q      <= (pos_q == 4'd0);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // A new item is loaded, or the current one steps down one digit.
      if (q_pop_o) begin
        state_q <= ST_EMIT;
        cmd_q   <= q_entry_i.cmd;
        value_q <= q_entry_i.value;
        pos_q   <= q_entry_i.top;
      end else if (emit) begin
        pos_q <= pos_q - 4'd1;
        if (cmd_q == i2a_pkg::CMD_DEC) begin
          value_q[31:0] <= rem_next;
        end
        if (done) begin
          state_q <= ST_IDLE;
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

`ifndef SYNTHESIS
  // Every emitted character is a decimal digit or a hex letter.
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((ascii_char_o >= 7'd48 && ascii_char_o <= 7'd57) ||
                     (ascii_char_o >= 7'd97 && ascii_char_o <= 7'd102) ||
                     (ascii_char_o >= 7'd65 && ascii_char_o <= 7'd70)))
    else $error("character outside the digit set");

  // Decimal work never starts above the ten-digit position.
  a_dec_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && cmd_q == i2a_pkg::CMD_DEC) |-> (pos_q <= 4'd9))
    else $error("decimal position out of range");

  // The decimal remainder stays below the next power of ten.
  a_dec_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && cmd_q == i2a_pkg::CMD_DEC && pos_q < 4'd9) |->
      ({2'b00, value_q[31:0]} < mult_tab[pos_q + 4'd1][1]))
    else $error("decimal remainder too large for its position");
`endif

endmodule

FILE: rtl/core/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: front, queue and back connected.
// Depends on i2a_pkg, i2a_front, i2a_queue and i2a_back.

// Each input item carries a mode and a 64-bit number; the block returns the
// number's digits as ASCII characters, most significant first, one character
// per output item, with leading zeros dropped and the final character marked
// by last_char_o. Zero gives a single '0'. The back end emits exactly one
// character per cycle while the output is not stalled; an item has 1 to 10
// digits for decimal, 1 to 8 for 32-bit hex and 1 to 16 for 64-bit hex. The
// front end classifies an item in the cycle it is accepted and parks it in a
// queue of QueueDepth items, so input items are taken while the back end
// still prints earlier ones, and when the next item is already queued its
// first character follows the previous item's last one without a gap.

module integer_to_ascii_formatter_unit #(
  parameter int unsigned QueueDepth = i2a_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  ascii_char_o,
  output logic        last_char_o
);

  i2a_pkg::entry_t push_entry;
  i2a_pkg::entry_t pop_entry;
  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;

  // Classification of incoming items.
  i2a_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  // Queue between the two halves.
  i2a_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Digit emission.
  i2a_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_entry_i    (pop_entry),
    .q_pop_o      (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for integer_to_ascii_formatter_unit: it sends numbers in every
// mode and compares each ASCII character against its own digit predictor.
// Depends on i2a_pkg and the RTL of the formatter only.
`timescale 1ns / 100ps

module testbench;

  // ASCII bases used by the digit predictor.
  localparam logic [6:0] ASCII_ZERO    = 7'd48;
  localparam logic [6:0] ASCII_LOWER_A = 7'd97;
  localparam logic [6:0] ASCII_UPPER_A = 7'd65;
  localparam int         MAX_REPORTS   = 10;
  localparam int         DRAIN_CYCLES  = 20;

  // One predicted output character.
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  cmd_i;
  logic [63:0] value_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [6:0]  ascii_char_o;
  logic        last_char_o;

  char_t expected_chars_q[$];
  int    fail_count     = 0;
  int    mismatch_count = 0;
  int    send_idle_pct  = 0;
  int    recv_idle_pct  = 0;

  integer_to_ascii_formatter_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

  // Free-running clock with a 10 ns period.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Predict the characters of one number, most significant digit first.
  function automatic void format_digits(input i2a_pkg::cmd_e mode, input logic [63:0] num);
    logic [6:0]  digits[16];
    logic [31:0] dec;
    logic [63:0] hex;
    logic [3:0]  nib;
    logic [6:0]  alpha;
    int          count;
    char_t       ch;
    count = 0;
    if (mode == i2a_pkg::CMD_DEC) begin
      dec = num[31:0];
      do begin
        digits[count] = ASCII_ZERO + 7'(dec % 10);
        count++;
        dec = dec / 10;
      end while (dec != 0);
    end else begin
      alpha = (mode == i2a_pkg::CMD_HEX_UP) ? ASCII_UPPER_A : ASCII_LOWER_A;
      hex   = (mode == i2a_pkg::CMD_HEX64) ? num : {32'd0, num[31:0]};
      do begin
        nib = hex[3:0];
        digits[count] = (nib <= 4'd9) ? ASCII_ZERO + 7'(nib) : alpha + 7'(nib) - 7'd10;
        count++;
        hex = hex >> 4;
      end while (hex != 0 && count < 16);
    end
    for (int k = count - 1; k >= 0; k--) begin
      ch.code = digits[k];
      ch.last = (k == 0);
      expected_chars_q.push_back(ch);
    end
  endfunction

  // Send one item, with random idle cycles first, and predict it once it is taken.
  task automatic send_number(input i2a_pkg::cmd_e mode, input logic [63:0] num);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= mode;
    value_i    <= num;
    do @(posedge clk_i); while (in_stall_o);
    format_digits(mode, num);
  endtask

  // Drop valid and hold until every predicted character has come out.
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_chars_q.size() != 0) @(negedge clk_i);
  endtask

  // Random number biased toward zero, short numbers and digit-count boundaries.
  function automatic logic [63:0] random_number();
    logic [63:0] raw;
    logic [31:0] pow;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0: return 64'd0;
      1: return 64'($urandom_range(1, 15));
      2: return raw >> (4 * $urandom_range(1, 15));
      3: begin
        pow = 32'd1;
        repeat ($urandom_range(1, 9)) pow = pow * 10;
        return {raw[63:32], pow - 32'($urandom_range(0, 1))};
      end
      4: return $urandom_range(0, 1) ? '1 : (64'd1 << $urandom_range(0, 63));
      default: return raw;
    endcase
  endfunction

  // Extremes of every mode, zero with and without upper bits, and digit-count edges.
  task automatic test_directed_values();
    send_number(i2a_pkg::CMD_DEC,    64'd0);
    send_number(i2a_pkg::CMD_DEC,    64'hFFFF_FFFF_0000_0000);
    send_number(i2a_pkg::CMD_DEC,    64'd9);
    send_number(i2a_pkg::CMD_DEC,    64'd10);
    send_number(i2a_pkg::CMD_DEC,    64'd999_999_999);
    send_number(i2a_pkg::CMD_DEC,    64'd1_000_000_000);
    send_number(i2a_pkg::CMD_DEC,    64'hDEAD_BEEF_FFFF_FFFF);
    send_number(i2a_pkg::CMD_HEX_LO, 64'd0);
    send_number(i2a_pkg::CMD_HEX_LO, 64'h0000_0000_00AB_CDEF);
    send_number(i2a_pkg::CMD_HEX_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CMD_HEX_LO, 64'h1234_5678_0000_0010);
    send_number(i2a_pkg::CMD_HEX_UP, 64'd0);
    send_number(i2a_pkg::CMD_HEX_UP, 64'h0000_0000_00AB_CDEF);
    send_number(i2a_pkg::CMD_HEX_UP, 64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CMD_HEX_UP, 64'h8000_0000_9876_543F);
    send_number(i2a_pkg::CMD_HEX64,  64'd0);
    send_number(i2a_pkg::CMD_HEX64,  64'd15);
    send_number(i2a_pkg::CMD_HEX64,  64'h0123_4567_89AB_CDEF);
    send_number(i2a_pkg::CMD_HEX64,  64'h8000_0000_0000_0000);
    send_number(i2a_pkg::CMD_HEX64,  64'hFFFF_FFFF_FFFF_FFFF);
    send_number(i2a_pkg::CMD_HEX64,  64'hFEDC_BA98_7654_3210);
  endtask

  // Random modes and numbers.
  task automatic test_random_values(input int count);
    repeat (count) send_number(i2a_pkg::cmd_e'($urandom_range(0, 3)), random_number());
  endtask

  // Bursts separated by a full drain, so the block restarts from empty each time.
  task automatic test_drain_pause();
    repeat (4) begin
      repeat ($urandom_range(2, 6))
        send_number(i2a_pkg::cmd_e'($urandom_range(0, 3)), random_number());
      wait_for_drain();
    end
  endtask

  // Capture each output item at the rising edge, check it and set the stall at the
  // falling edge.
  initial begin
    logic       got;
    logic [6:0] got_code;
    logic       got_last;
    char_t      want;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      got      = rst_ni && out_valid_o && !out_stall_i;
      got_code = ascii_char_o;
      got_last = last_char_o;
      @(negedge clk_i);
      if (got) begin
        if (expected_chars_q.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected character: ascii_char %0d last_char %0b", got_code, got_last);
        end else begin
          want = expected_chars_q.pop_front();
          if (got_code !== want.code || got_last !== want.last) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: ascii_char exp %0d got %0d, last_char exp %0b got %0b",
                       want.code, got_code, want.last, got_last);
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Main sequence: reset, then the tests under each idling pattern.
  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    cmd_i      = i2a_pkg::CMD_DEC;
    value_i    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 17;
    recv_idle_pct = 61;
    test_directed_values();
    test_random_values(125);

    send_idle_pct = 61;
    recv_idle_pct = 17;
    test_drain_pause();
    test_random_values(125);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_values(125);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/i2a_pkg.sv
rtl/core/i2a_front.sv
rtl/core/i2a_queue.sv
rtl/core/i2a_back.sv
rtl/core/integer_to_ascii_formatter_unit.sv
tb/sv/testbench.sv
